@@ sv/pwh_pkg.sv @@
// Shared types, constants and helpers of the horizontal Prewitt edge filter.
`timescale 1ns / 1ps
package pwh_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int SUM_W      = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  // floor(x/3) for x <= 765 as (x * 683) >> 11
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  localparam int DIV3_P_W = 21;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pwh_in_t;

  typedef struct packed {
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             run_last;
    logic             frame_last;
  } pwh_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pwh_pix_t;

  typedef struct packed {
    logic emit_prev;
    logic interior;
    logic row_emit;
    logic last_row;
    logic row_end;
  } pwh_flags_t;

  typedef struct packed {
    pwh_flags_t       flags;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    pwh_pix_t         border;
    pwh_pix_t         mid;
    pwh_pix_t         bot;
  } pwh_entry_t;

  function automatic logic [7:0] div3(input logic [SUM_W-1:0] x);
    logic [DIV3_P_W-1:0] p;
    p = DIV3_P_W'(x) * DIV3_P_W'(DIV3_MUL);
    return p[DIV3_SH +: 8];
  endfunction

endpackage

@@ sv/pwh_front.sv @@
// Front end: pixel intake, position counters, line buffers, window and column sums.
`timescale 1ns / 1ps
module pwh_front import pwh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pwh_in_t               in_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output pwh_entry_t            q_entry
);

  logic [COL_W-1:0] wlast_r;
  logic [ROW_W-1:0] hlast_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  logic             s1_v_r;
  pwh_pix_t         s1_bot_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  pwh_flags_t       s1_flags_r;

  pwh_pix_t line_prev  [MAX_WIDTH];
  pwh_pix_t line_prev2 [MAX_WIDTH];
  pwh_pix_t rd_prev_r;
  pwh_pix_t rd_prev2_r;
  logic     byp_r;
  pwh_pix_t byp_data_r;
  logic             wr2_v_r;
  logic [COL_W-1:0] wr2_addr_r;

  pwh_pix_t win_r [6];

  logic       accept;
  pwh_flags_t flags;
  pwh_pix_t   top;
  pwh_pix_t   bot_in;

  logic [CFG_WID_W-1:0] wval;
  logic [CFG_HGT_W-1:0] hval;

  function automatic logic [SUM_W-1:0] abs_sum(input logic [7:0] r0, input logic [7:0] r1,
                                               input logic [7:0] r2, input logic [7:0] l0,
                                               input logic [7:0] l1, input logic [7:0] l2);
    logic [SUM_W-1:0] sr;
    logic [SUM_W-1:0] sl;
    sr = SUM_W'(r0) + SUM_W'(r1) + SUM_W'(r2);
    sl = SUM_W'(l0) + SUM_W'(l1) + SUM_W'(l2);
    return (sr >= sl) ? (sr - sl) : (sl - sr);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_v_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign q_push    = s1_v_r && !q_full;
  assign bot_in    = '{r: in_data.in_red, g: in_data.in_green, b: in_data.in_blue};
  assign top       = byp_r ? byp_data_r : rd_prev2_r;
  assign wval      = cfg_data[CFG_WID_W-1:0];
  assign hval      = cfg_data[CFG_HGT_W-1:0];

  always_comb begin
    flags.row_end   = col_r >= wlast_r;
    flags.last_row  = row_r >= hlast_r;
    flags.emit_prev = (row_r != '0) && (col_r != '0);
    flags.row_emit  = (row_r != '0) && flags.row_end;
    flags.interior  = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2)) &&
                      (row_r <= hlast_r) && (col_r <= wlast_r);
  end

  // configuration: hold clamped last column and last row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= COL_W'(RST_WIDTH - 1);
      hlast_r <= ROW_W'(RST_HEIGHT - 1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (wval == '0) wlast_r <= '0;
          else if (wval > CFG_WID_W'(MAX_WIDTH)) wlast_r <= COL_W'(MAX_WIDTH - 1);
          else wlast_r <= COL_W'(wval - CFG_WID_W'(1));
        end
        CFG_IMAGE_HEIGHT: begin
          if (hval == '0) hlast_r <= '0;
          else if (hval > CFG_HGT_W'(MAX_HEIGHT)) hlast_r <= ROW_W'(MAX_HEIGHT - 1);
          else hlast_r <= ROW_W'(hval - CFG_HGT_W'(1));
        end
        default: ;
      endcase
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (flags.row_end) begin
        col_r <= '0;
        row_r <= flags.last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      wr2_v_r <= 1'b0;
    end else begin
      wr2_v_r <= accept;
      if (accept) s1_v_r <= 1'b1;
      else if (q_push) s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bot_r   <= bot_in;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_flags_r <= flags;
      wr2_addr_r <= col_r;
    end
  end

  // row i-1 buffer: read old and write the new pixel at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_prev_r      <= line_prev[col_r];
      line_prev[col_r] <= bot_in;
    end
  end

  // row i-2 buffer: written in the cycle after intake; forward that pending write
  always_ff @(posedge clk) begin
    if (wr2_v_r) line_prev2[wr2_addr_r] <= rd_prev_r;
    if (accept) begin
      rd_prev2_r <= line_prev2[col_r];
      byp_r      <= wr2_v_r && (wr2_addr_r == col_r);
      byp_data_r <= rd_prev_r;
    end
  end

  // advance the window as each beat leaves for the queue
  always_ff @(posedge clk) begin
    if (q_push) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top;
      win_r[1] <= rd_prev_r;
      win_r[2] <= s1_bot_r;
    end
  end

  always_comb begin
    q_entry.flags  = s1_flags_r;
    q_entry.row    = s1_row_r;
    q_entry.col    = s1_col_r;
    q_entry.sum_r  = abs_sum(top.r, rd_prev_r.r, s1_bot_r.r, win_r[3].r, win_r[4].r, win_r[5].r);
    q_entry.sum_g  = abs_sum(top.g, rd_prev_r.g, s1_bot_r.g, win_r[3].g, win_r[4].g, win_r[5].g);
    q_entry.sum_b  = abs_sum(top.b, rd_prev_r.b, s1_bot_r.b, win_r[3].b, win_r[4].b, win_r[5].b);
    q_entry.border = win_r[1];
    q_entry.mid    = rd_prev_r;
    q_entry.bot    = s1_bot_r;
  end

endmodule

@@ sv/pwh_queue.sv @@
// Short FIFO between the front end and the emission back end.
`timescale 1ns / 1ps
module pwh_queue import pwh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pwh_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output pwh_entry_t head
);

  pwh_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign full      = count_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop) count_r <= count_r + (Q_PTR_W + 1)'(1);
      else if (pop && !push) count_r <= count_r - (Q_PTR_W + 1)'(1);
    end
  end

endmodule

@@ sv/pwh_back.sv @@
// Back end: divide by three and emit each beat's results into the output register.
`timescale 1ns / 1ps
module pwh_back import pwh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  pwh_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output pwh_out_t   out_data
);

  localparam int SLOT_PREV = 0;
  localparam int SLOT_ROW  = 1;
  localparam int SLOT_LAST = 2;

  logic       cur_v_r;
  logic [2:0] cur_mask_r;
  pwh_entry_t cur_r;
  logic       out_v_r;
  pwh_out_t   out_r;

  logic       out_free;
  logic       emit;
  logic [2:0] sel;
  logic [2:0] mask_after;
  logic       cur_done;
  pwh_pix_t   px;
  pwh_out_t   res;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    out_free   = !out_v_r || !out_stall;
    emit       = cur_v_r && (cur_mask_r != '0) && out_free;
    sel        = cur_mask_r & (~cur_mask_r + 3'd1);
    mask_after = emit ? (cur_mask_r & ~sel) : cur_mask_r;
    cur_done   = !cur_v_r || (mask_after == '0);
    q_pop      = cur_done && q_not_empty;

    res = '0;
    px  = cur_r.bot;
    if (sel[SLOT_PREV]) begin
      if (cur_r.flags.interior) begin
        px = '{r: div3(cur_r.sum_r), g: div3(cur_r.sum_g), b: div3(cur_r.sum_b)};
      end else begin
        px = cur_r.border;
      end
      res.out_row = cur_r.row - ROW_W'(1);
      res.out_col = cur_r.col - COL_W'(1);
    end else if (sel[SLOT_ROW]) begin
      px          = cur_r.mid;
      res.out_row = cur_r.row - ROW_W'(1);
      res.out_col = cur_r.col;
    end else begin
      res.out_row    = cur_r.row;
      res.out_col    = cur_r.col;
      res.frame_last = cur_r.flags.row_end;
    end
    res.out_red   = px.r;
    res.out_green = px.g;
    res.out_blue  = px.b;
    res.run_last  = mask_after == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r    <= 1'b0;
      cur_mask_r <= '0;
      out_v_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_v_r               <= 1'b1;
        cur_mask_r[SLOT_PREV] <= q_head.flags.emit_prev;
        cur_mask_r[SLOT_ROW]  <= q_head.flags.row_emit;
        cur_mask_r[SLOT_LAST] <= q_head.flags.last_row;
      end else if (cur_done) begin
        cur_v_r    <= 1'b0;
        cur_mask_r <= '0;
      end else begin
        cur_mask_r <= mask_after;
      end
      if (emit) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (emit)  out_r <= res;
  end

endmodule

@@ sv/prewitt_horizontal_edge_filter.sv @@
// Top level of the 3x3 horizontal Prewitt edge filter for RGB raster streams.
`timescale 1ns / 1ps
// Pixels enter in raster order, one beat per pixel, and leave as finished pixels tagged
// with their row and column. Each channel of an interior pixel becomes
// floor(|sum over three rows of right minus left neighbor| / 3); pixels of the first and
// last rows and columns pass through unchanged. A beat at (i,j) releases pixel (i-1,j-1),
// at a row end also (i-1,j), and in the last row the beat itself, so a beat yields zero to
// three results; run_last marks the last of them and frame_last the bottom right pixel.
// The block takes one beat per cycle while each beat yields at most one result and the
// output does not stall; the emission stage then writes one result per cycle into the
// output register, so a beat with several results holds it until all are written. A
// four-entry queue between intake and emission absorbs these bursts and lets either side
// stall alone. Beats pass the intake register, queue, current-beat and output registers.
// Width and height are clamped to 1..1024 and 1..4096 when written; write them only while
// the stream is idle. Line buffers start uninitialized and need no clearing pass.
module prewitt_horizontal_edge_filter import pwh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pwh_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pwh_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  pwh_entry_t q_entry;
  pwh_entry_t q_head;

  // intake: counters, line buffers, window and column sums
  pwh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // decouple intake from emission bursts
  pwh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // emission: divide, pick border or filtered value, drive the output register
  pwh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
